// File: rtl/sfs_pkg.sv
// shared constants, types and the coil pattern table for the stepper full-step sequencer
// no dependencies
package sfs_pkg;

  localparam int TICK_RATE = 1000000;
  localparam int PER_W     = 20;
  localparam int SPD_W     = 20;
  localparam int STEPS_W   = 31;
  localparam int OP_W      = 2;
  localparam int COIL_W    = 4;
  localparam int DEN_W     = SPD_W + 2;
  localparam int REM_W     = DEN_W + 1;
  localparam int DIV_N     = PER_W;
  localparam int CNT_W     = $clog2(DIV_N);
  localparam int IDX_W     = 1;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

  localparam logic [IDX_W-1:0] REG_DIRECTION = 1'd0;
  localparam logic [IDX_W-1:0] REG_SPEED     = 1'd1;

  localparam logic [1:0] PHASE_CW  = 2'd0;
  localparam logic [1:0] PHASE_CCW = 2'd3;

  typedef struct packed {
    logic capture;
    logic div_init;
    logic div_step;
    logic exec;
  } sfs_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_last;
  } sfs_stat_t;

  function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      2'd0:    pat = 4'hA;
      2'd1:    pat = 4'h6;
      2'd2:    pat = 4'h5;
      2'd3:    pat = 4'h9;
      default: pat = 4'hA;
    endcase
    return pat;
  endfunction

endpackage

// File: rtl/stepper_full_step_sequencer.sv
// top level of the four-phase full-step stepper sequencer
// depends on sfs_pkg, sfs_ctrl, sfs_dp
//
// usage:
//   in_*   : one word per tick or command; in_tuser carries the op
//            (tick, start, step count, stop), in_tdata the step count
//   out_*  : one result word per input word: coil levels, run flag,
//            and whether this word drove a new pattern
//   cfg_*  : register writes (direction, step speed); the user makes them
//            only while the block is idle, which the block does not enforce; cfg_ready is always high
// sequence: a tick, stop or zero step count is applied from the check
//   state after acceptance; start and a nonzero step count first run the
//   period division, one quotient bit per cycle, then apply in the finish state
// throughput: one word in flight; the next word is accepted in the cycle
//   its predecessor's result is taken, or any time after
// reset: coils off, stopped, phase aligned clockwise, period 1, speed 1
// stall: a result waits in the output register while out_tready is low,
//   and in_tready stays low until it is taken
module stepper_full_step_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [30:0] steps
  input  logic [1:0]                  in_tuser,   // [1:0] op
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [3:0] coils, [4] running, [5] stepped
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sfs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sfs_pkg::SPD_W-1:0]   cfg_data
);
  import sfs_pkg::*;

  sfs_cmd_t          cmd;
  sfs_stat_t         stat;
  logic [COIL_W-1:0] res_coils;
  logic              res_running;
  logic              res_stepped;

  assign cfg_ready = 1'b1;

  sfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sfs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .in_op       (in_tuser),
    .in_steps    (in_tdata[STEPS_W-1:0]),
    .cmd         (cmd),
    .stat        (stat),
    .res_coils   (res_coils),
    .res_running (res_running),
    .res_stepped (res_stepped)
  );

  assign out_tdata = {2'b00, res_stepped, res_running, res_coils};

  a_step_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[5]) |-> (out_tdata[3:0] == 4'hA || out_tdata[3:0] == 4'h6 ||
                                      out_tdata[3:0] == 4'h5 || out_tdata[3:0] == 4'h9))
    else $error("stepped word carries an invalid coil pattern");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.div_init || cmd.exec) |-> !in_tready)
    else $error("input accepted while an item is in progress");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

// File: rtl/sfs_ctrl.sv
// control state machine: item capture, period division sequencing, result handoff
// depends on sfs_pkg
module sfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  sfs_pkg::sfs_stat_t stat,
  output sfs_pkg::sfs_cmd_t  cmd
);
  import sfs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.needs_div) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/sfs_dp.sv
// datapath: config registers, bit-serial period divider, phase/count state, result register
// depends on sfs_pkg
module sfs_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_write,
  input  logic [sfs_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [sfs_pkg::SPD_W-1:0]    cfg_wdata,
  input  logic [sfs_pkg::OP_W-1:0]     in_op,
  input  logic [sfs_pkg::STEPS_W-1:0]  in_steps,
  input  sfs_pkg::sfs_cmd_t            cmd,
  output sfs_pkg::sfs_stat_t           stat,
  output logic [sfs_pkg::COIL_W-1:0]   res_coils,
  output logic                         res_running,
  output logic                         res_stepped
);
  import sfs_pkg::*;

  localparam logic [DIV_N-1:0] TICK_VEC = DIV_N'(TICK_RATE);

  logic               dir_r;
  logic [SPD_W-1:0]   speed_r;
  logic [OP_W-1:0]    op_r;
  logic [STEPS_W-1:0] steps_r;

  logic [DEN_W-1:0]   den_r;
  logic [REM_W-1:0]   rem_r;
  logic [PER_W-1:0]   quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   bit_idx;
  logic [REM_W-1:0]   trial;
  logic               fits;

  logic [1:0]         phase_r, phase_nxt;
  logic [COIL_W-1:0]  coil_r, coil_nxt;
  logic               run_r, run_nxt;
  logic [STEPS_W-1:0] remain_r, remain_nxt;
  logic [PER_W-1:0]   period_r, period_nxt;
  logic [PER_W-1:0]   tick_r, tick_nxt;
  logic               stepped_nxt;
  logic               stepped_r;

  logic [PER_W-1:0]   tick_inc;
  logic [STEPS_W-1:0] remain_dec;
  logic [1:0]         aligned;
  logic [PER_W-1:0]   new_period;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= 1'b0;
      speed_r <= SPD_W'(1);
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_DIRECTION: dir_r   <= cfg_wdata[0];
        REG_SPEED:     speed_r <= cfg_wdata;
        default:       dir_r   <= dir_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      steps_r <= in_steps;
    end
  end

  assign stat.needs_div = (op_r == OP_START) || ((op_r == OP_COUNT) && (steps_r != '0));
  assign stat.div_last  = (cnt_r == CNT_W'(DIV_N - 1));

  // restoring divide of the tick rate by four times the speed, one quotient bit a cycle
  assign bit_idx = CNT_W'(DIV_N - 1) - cnt_r;
  assign trial   = {rem_r[REM_W-2:0], TICK_VEC[bit_idx]};
  assign fits    = (trial >= REM_W'(den_r));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den_r <= {((speed_r == '0) ? SPD_W'(1) : speed_r), 2'b00};
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= fits ? (trial - REM_W'(den_r)) : trial;
      quo_r <= {quo_r[PER_W-2:0], fits};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign aligned    = dir_r ? PHASE_CCW : PHASE_CW;
  assign new_period = (quo_r == '0) ? PER_W'(1) : quo_r;
  assign tick_inc   = tick_r + PER_W'(1);
  assign remain_dec = remain_r - STEPS_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    coil_nxt    = coil_r;
    run_nxt     = run_r;
    remain_nxt  = remain_r;
    period_nxt  = period_r;
    tick_nxt    = tick_r;
    stepped_nxt = 1'b0;
    case (op_r)
      OP_TICK: begin
        if (run_r) begin
          tick_nxt = tick_inc;
          if (tick_inc >= period_r) begin
            tick_nxt    = '0;
            coil_nxt    = coil_pattern(phase_r);
            stepped_nxt = 1'b1;
            phase_nxt   = dir_r ? (phase_r - 2'd1) : (phase_r + 2'd1);
            if (remain_r != '0) begin
              remain_nxt = remain_dec;
              if (remain_dec == '0) begin
                run_nxt   = 1'b0;
                phase_nxt = aligned;
              end
            end
          end
        end
      end
      OP_START: begin
        period_nxt = new_period;
        run_nxt    = 1'b1;
        phase_nxt  = aligned;
        tick_nxt   = '0;
      end
      OP_COUNT: begin
        remain_nxt = steps_r;
        phase_nxt  = aligned;
        if (steps_r == '0) begin
          run_nxt = 1'b0;
        end else begin
          period_nxt = new_period;
          run_nxt    = 1'b1;
          tick_nxt   = '0;
        end
      end
      OP_STOP: begin
        run_nxt   = 1'b0;
        phase_nxt = aligned;
      end
      default: begin
        run_nxt = run_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PHASE_CW;
      coil_r    <= '0;
      run_r     <= 1'b0;
      remain_r  <= '0;
      period_r  <= PER_W'(1);
      tick_r    <= '0;
      stepped_r <= 1'b0;
    end else if (cmd.exec) begin
      phase_r   <= phase_nxt;
      coil_r    <= coil_nxt;
      run_r     <= run_nxt;
      remain_r  <= remain_nxt;
      period_r  <= period_nxt;
      tick_r    <= tick_nxt;
      stepped_r <= stepped_nxt;
    end
  end

  assign res_coils   = coil_r;
  assign res_running = run_r;
  assign res_stepped = stepped_r;

endmodule
